/* sv/triangle_wave_generator_assert.svh */
// Assertion macros shared by the triangle wave generator RTL.
`ifndef TRIANGLE_WAVE_GENERATOR_ASSERT_SVH
`define TRIANGLE_WAVE_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TWG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TWG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/twg_pkg.sv */
// Types and constants shared by the triangle wave generator modules.
`default_nettype none

package twg_pkg;

  localparam int unsigned TimeW   = 32;  // timestamp and period width
  localparam int unsigned CfgW    = 32;  // config write data width
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgNum  = 3;   // registers in the map
  localparam int unsigned ParmW   = 16;  // mean and deviation width
  localparam int unsigned LvlW    = 25;  // output level, Q.8 signed
  localparam int unsigned FracW   = 8;
  localparam int unsigned QFrac   = FracW + 1;       // 2*d/T in Q.8 -> d*512/T
  localparam int unsigned QW      = 27;              // ramp quotient, clipped
  localparam int unsigned QmW     = QW + 1;          // quotient minus one, signed
  localparam int unsigned ProdW   = QmW + 1 + ParmW; // serial product width
  localparam int unsigned SumW    = ProdW + 1;
  localparam int unsigned DivCntW = $clog2(QW);
  localparam int unsigned MulCntW = $clog2(ParmW);

  localparam logic [TimeW-1:0]        PeriodRst = TimeW'(1000);
  localparam logic signed [QmW-1:0]   QOne      = QmW'(1 << FracW);
  localparam logic signed [LvlW-1:0]  LvlMax    = {1'b0, {(LvlW-1){1'b1}}};
  localparam logic signed [LvlW-1:0]  LvlMin    = {1'b1, {(LvlW-1){1'b0}}};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PERIOD = 2'd0,
    CFG_MEAN   = 2'd1,
    CFG_DEV    = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BOUND,
    ST_EVAL,
    ST_DIFF,
    ST_DIV0,
    ST_DIV,
    ST_MUL0,
    ST_MUL,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    BR_FLAT,
    BR_RISE,
    BR_FALL
  } branch_e;

  // Status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

/* sv/twg_chan_if.sv */
// Valid/ready channel interfaces for timestamps in and wave levels out.
`default_nettype none

interface twg_time_if;
  logic                       valid;
  logic                       ready;
  logic [twg_pkg::TimeW-1:0]  time_now;

  modport source (output valid, output time_now, input ready);
  modport sink   (input valid, input time_now, output ready);
endinterface

interface twg_level_if;
  logic                             valid;
  logic                             ready;
  logic signed [twg_pkg::LvlW-1:0]  level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

`default_nettype wire

/* sv/twg_div.sv */
// Bit-serial restoring divider: clipped quotient of dvd*512/dvs, one bit per cycle.
`default_nettype none
`include "triangle_wave_generator_assert.svh"

module twg_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [twg_pkg::TimeW-1:0]     dvd_i,
  input  logic [twg_pkg::TimeW-1:0]     dvs_i,
  output logic [twg_pkg::QW-1:0]        quot_o,
  output twg_pkg::unit_stat_t           stat_o
);

  // quotient bits above QW exist iff dvd >= dvs * 2^HiW
  localparam int unsigned HiW = twg_pkg::QW - twg_pkg::QFrac;
  localparam logic [twg_pkg::DivCntW-1:0] CntLast = twg_pkg::DivCntW'(twg_pkg::QW - 1);

  logic [twg_pkg::TimeW-1:0]   rem_q, rem_d;
  logic [twg_pkg::QW-1:0]      sh_q, sh_d;
  logic [twg_pkg::DivCntW-1:0] cnt_q;
  logic                        busy_q, done_q;
  logic                        ovf;
  logic [twg_pkg::TimeW:0]     trial, trial_sub;
  logic                        ge;

  assign ovf = (dvs_i[twg_pkg::TimeW-1 -: HiW] == '0) &&
               (dvd_i >= {dvs_i[twg_pkg::TimeW-HiW-1:0], {HiW{1'b0}}});

  // shift the next dividend bit into the partial remainder
  assign trial     = {rem_q, sh_q[twg_pkg::QW-1]};
  assign trial_sub = trial - {1'b0, dvs_i};
  assign ge        = (trial >= {1'b0, dvs_i});

  always_comb begin
    rem_d = ge ? trial_sub[twg_pkg::TimeW-1:0] : trial[twg_pkg::TimeW-1:0];
    sh_d  = {sh_q[twg_pkg::QW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (ovf) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= twg_pkg::TimeW'(dvd_i[twg_pkg::TimeW-1:HiW]);
      sh_q  <= ovf ? '1 : {dvd_i[HiW-1:0], {twg_pkg::QFrac{1'b0}}};
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
    end
  end

  assign quot_o      = sh_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  `TWG_ASSERT_NEXT(a_div_start_runs, clk_i, rst_ni, start_i, busy_q || done_q,
                   "divider ignored a start")

endmodule

`default_nettype wire

/* sv/twg_mul.sv */
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
`default_nettype none
`include "triangle_wave_generator_assert.svh"

module twg_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [twg_pkg::QmW-1:0]    mcand_i,
  input  logic signed [twg_pkg::ParmW-1:0]  mplier_i,
  output logic signed [twg_pkg::ProdW-1:0]  prod_o,
  output twg_pkg::unit_stat_t               stat_o
);

  localparam logic [twg_pkg::MulCntW-1:0] CntLast =
    twg_pkg::MulCntW'(twg_pkg::ParmW - 1);

  logic signed [twg_pkg::QmW:0]   hi_q, hi_d;
  logic [twg_pkg::ParmW-1:0]      lo_q, lo_d;
  logic [twg_pkg::MulCntW-1:0]    cnt_q;
  logic                           busy_q, done_q;
  logic signed [twg_pkg::QmW:0]   mc, addend, psum;

  assign mc = (twg_pkg::QmW + 1)'(mcand_i);

  always_comb begin
    // sign bit of the multiplier carries negative weight
    if (!lo_q[0]) begin
      addend = '0;
    end else if (cnt_q == CntLast) begin
      addend = -mc;
    end else begin
      addend = mc;
    end
    psum = hi_q + addend;
    hi_d = psum >>> 1;
    lo_d = {psum[0], lo_q[twg_pkg::ParmW-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q <= '0;
      lo_q <= mplier_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign prod_o      = {hi_q, lo_q};
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  `TWG_ASSERT_NEXT(a_mul_done_pulse, clk_i, rst_ni, done_q, !done_q,
                   "multiplier done held longer than one cycle")

endmodule

`default_nettype wire

/* sv/triangle_wave_generator.sv */
// Triangle wave generator top level: cycle tracking, sequencing and output stage.
//
//   channel   dir  payload                        handshake
//   time_i    in   time_now  32b unsigned         valid/ready
//   level_o   out  level     25b signed, Q.8      valid/ready
//   cfg       in   cfg_idx_i 2b, cfg_data_i 32b   cfg_we_i, no back-pressure
//
// One item at a time. On a ramp an item passes the radix-2 divide by the
// period, then the serial multiply by the deviation, with sequencing steps
// around them. On flat parts the divide is skipped; a clipped quotient makes
// the divider finish without stepping through the quotient bits.
// Reset (async, active low) loads period 1000, mean and deviation 0, no cycle.
// The output register holds a result until taken; the next input is taken
// meanwhile, and a new result waits in the last step while the old one is held.
`default_nettype none
`include "triangle_wave_generator_assert.svh"

module triangle_wave_generator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [twg_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [twg_pkg::CfgW-1:0]        cfg_data_i,
  twg_time_if.sink                        time_i,
  twg_level_if.source                     level_o
);

  twg_pkg::state_e                   state_q, state_d;
  logic [twg_pkg::TimeW-1:0]         period_q;
  logic signed [twg_pkg::ParmW-1:0]  mean_q, dev_q;
  logic [twg_pkg::TimeW-1:0]         start_q;

  logic [twg_pkg::TimeW-1:0]         t_q, rise_q, fall_q, d_q;
  twg_pkg::branch_e                  br_q, br_d;
  logic [twg_pkg::QW-1:0]            q_q;
  logic                              out_valid_q;
  logic signed [twg_pkg::LvlW-1:0]   level_q;

  logic                              cfg_hit;
  logic                              restart;
  logic [twg_pkg::TimeW-1:0]         s_new;
  logic [twg_pkg::TimeW-1:0]         d_d;
  logic                              out_free, out_ld;
  logic                              div_start, mul_start;
  logic [twg_pkg::QW-1:0]            div_quot;
  twg_pkg::unit_stat_t               div_stat, mul_stat;
  logic signed [twg_pkg::QmW-1:0]    qm;
  logic signed [twg_pkg::ProdW-1:0]  prod;
  logic signed [twg_pkg::SumW-1:0]   mean_ext, prod_ext, lvl_sum;

  function automatic logic signed [twg_pkg::LvlW-1:0] sat_level(
    input logic signed [twg_pkg::SumW-1:0] v
  );
    logic signed [twg_pkg::SumW-1:0] vmax, vmin;
    vmax = twg_pkg::SumW'(twg_pkg::LvlMax);
    vmin = twg_pkg::SumW'(twg_pkg::LvlMin);
    if (v > vmax) begin
      return twg_pkg::LvlMax;
    end else if (v < vmin) begin
      return twg_pkg::LvlMin;
    end else begin
      return v[twg_pkg::LvlW-1:0];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers; any write to a mapped register drops the cycle
  assign cfg_hit = cfg_we_i && (cfg_idx_i < twg_pkg::CfgIdxW'(twg_pkg::CfgNum));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= twg_pkg::PeriodRst;
      mean_q   <= '0;
      dev_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (twg_pkg::cfg_idx_e'(cfg_idx_i))
        twg_pkg::CFG_PERIOD: period_q <= cfg_data_i[twg_pkg::TimeW-1:0];
        twg_pkg::CFG_MEAN:   mean_q   <= cfg_data_i[twg_pkg::ParmW-1:0];
        twg_pkg::CFG_DEV:    dev_q    <= cfg_data_i[twg_pkg::ParmW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Cycle tracking
  assign restart = (start_q == '0) || (t_q >= fall_q);
  assign s_new   = restart ? t_q : start_q;

  always_comb begin
    priority if (t_q < s_new) begin
      br_d = twg_pkg::BR_FLAT;
    end else if (t_q < rise_q) begin
      br_d = twg_pkg::BR_RISE;
    end else if (t_q < fall_q) begin
      br_d = twg_pkg::BR_FALL;
    end else begin
      br_d = twg_pkg::BR_FLAT;
    end
  end

  // offset into the current half cycle
  assign d_d = t_q - start_q - ((br_q == twg_pkg::BR_FALL) ? period_q : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
    end else if (cfg_hit) begin
      start_q <= '0;
    end else if (state_q == twg_pkg::ST_EVAL) begin
      start_q <= s_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  assign out_free = !out_valid_q || level_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= twg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    mul_start = 1'b0;
    out_ld    = 1'b0;
    unique case (state_q)
      twg_pkg::ST_IDLE: begin
        if (time_i.valid) begin
          state_d = twg_pkg::ST_BOUND;
        end
      end
      twg_pkg::ST_BOUND: state_d = twg_pkg::ST_EVAL;
      twg_pkg::ST_EVAL:  state_d = twg_pkg::ST_DIFF;
      twg_pkg::ST_DIFF:  state_d = twg_pkg::ST_DIV0;
      twg_pkg::ST_DIV0: begin
        if (br_q == twg_pkg::BR_FLAT) begin
          state_d = twg_pkg::ST_MUL0;
        end else begin
          div_start = 1'b1;
          state_d   = twg_pkg::ST_DIV;
        end
      end
      twg_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_d = twg_pkg::ST_MUL0;
        end
      end
      twg_pkg::ST_MUL0: begin
        mul_start = 1'b1;
        state_d   = twg_pkg::ST_MUL;
      end
      twg_pkg::ST_MUL: begin
        if (mul_stat.done) begin
          state_d = twg_pkg::ST_OUT;
        end
      end
      twg_pkg::ST_OUT: begin
        if (out_free) begin
          out_ld  = 1'b1;
          state_d = twg_pkg::ST_IDLE;
        end
      end
      default: state_d = twg_pkg::ST_IDLE;
    endcase
  end

  assign time_i.ready = (state_q == twg_pkg::ST_IDLE);

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (time_i.valid && time_i.ready) begin
      t_q <= time_i.time_now;
    end
    if (state_q == twg_pkg::ST_BOUND) begin
      rise_q <= start_q + period_q;
      fall_q <= start_q + {period_q[twg_pkg::TimeW-2:0], 1'b0};
    end
    if (state_q == twg_pkg::ST_EVAL) begin
      br_q <= br_d;
    end
    if (state_q == twg_pkg::ST_DIFF) begin
      d_q <= d_d;
    end
    // flat parts use q = 0, so the product is -256 * deviation
    if (state_q == twg_pkg::ST_DIV0) begin
      q_q <= '0;
    end else if (state_q == twg_pkg::ST_DIV && div_stat.done) begin
      q_q <= div_quot;
    end
    if (out_ld) begin
      level_q <= sat_level(lvl_sum);
    end
  end

  // ---------------------------------------------------------------------------
  // Arithmetic units
  twg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (d_q),
    .dvs_i   (period_q),
    .quot_o  (div_quot),
    .stat_o  (div_stat)
  );

  assign qm = $signed({1'b0, q_q}) - twg_pkg::QOne;

  twg_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (qm),
    .mplier_i (dev_q),
    .prod_o   (prod),
    .stat_o   (mul_stat)
  );

  assign mean_ext = twg_pkg::SumW'($signed({mean_q, {twg_pkg::FracW{1'b0}}}));
  assign prod_ext = twg_pkg::SumW'(prod);
  assign lvl_sum  = mean_ext + ((br_q == twg_pkg::BR_FALL) ? -prod_ext : prod_ext);

  // ---------------------------------------------------------------------------
  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= 1'b1;
    end else if (level_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign level_o.valid = out_valid_q;
  assign level_o.level = level_q;

  `TWG_ASSERT_NEXT(a_cfg_clears_start, clk_i, rst_ni, cfg_hit, start_q == '0,
                   "register write did not clear the cycle start")
  `TWG_ASSERT_NEXT(a_in_starts_seq, clk_i, rst_ni, time_i.valid && time_i.ready,
                   state_q == twg_pkg::ST_BOUND, "input transfer did not start the sequence")
  `TWG_ASSERT_NOW(a_div_done_expected, clk_i, rst_ni, div_stat.done,
                  state_q == twg_pkg::ST_DIV, "divider finished outside the divide step")

endmodule

`default_nettype wire
